// File: rtl/bfp_pkg.sv
// ----------------------------------------------------------------------------
// Border fade pixel package
// Widths, mode codes and pipeline payload types shared by the border fade core.
// ----------------------------------------------------------------------------
package bfp_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int CORD_W     = 12;
    localparam int STR_W      = 12;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int NUM_W      = STR_W + CH_W;
    localparam int DIV_STEPS  = 2;
    localparam int NUM_DIV    = CH_W / DIV_STEPS;

    localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);
    localparam logic [CH_W-1:0]  CH_MAX    = {CH_W{1'b1}};

    localparam logic [1:0] MODE_FADE  = 2'd0;
    localparam logic [1:0] MODE_WHITE = 2'd1;
    localparam logic [1:0] MODE_PASS  = 2'd2;

    typedef logic [CH_W-1:0] chan_t;
    typedef chan_t [NUM_CH-1:0] pix_t;

    typedef struct packed {
        logic [CORD_W-1:0] edge_dist;
        pix_t              chan;
    } edge_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [STR_W-1:0] fact;
        pix_t             diff;
        pix_t             chan;
    } class_t;

    // acc holds the partial remainder above the dividend and quotient bits.
    typedef struct packed {
        logic [1:0]                   mode;
        logic [NUM_CH-1:0][NUM_W-1:0] acc;
        pix_t                         chan;
    } div_t;

endpackage

// File: rtl/bfp_edge.sv
// ----------------------------------------------------------------------------
// Border fade edge distance stage
// Registers the smallest distance from the pixel to any frame edge.
// ----------------------------------------------------------------------------
module bfp_edge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        in_valid,
    input  logic [bfp_pkg::CORD_W-1:0]  col,
    input  logic [bfp_pkg::CORD_W-1:0]  row,
    input  bfp_pkg::pix_t               in_pix,
    input  logic [bfp_pkg::DIM_W-1:0]   image_width,
    input  logic [bfp_pkg::DIM_W-1:0]   image_height,
    output logic                        out_valid,
    output bfp_pkg::edge_t              out_data
);

    logic                        vld_reg;
    bfp_pkg::edge_t              data_reg;
    bfp_pkg::edge_t              data_next;
    logic [bfp_pkg::DIM_W-1:0]   w_sat;
    logic [bfp_pkg::DIM_W-1:0]   h_sat;
    logic signed [bfp_pkg::DIM_W:0] dx0;
    logic signed [bfp_pkg::DIM_W:0] dx1;
    logic signed [bfp_pkg::DIM_W:0] dy0;
    logic signed [bfp_pkg::DIM_W:0] dy1;
    logic signed [bfp_pkg::DIM_W:0] mx;
    logic signed [bfp_pkg::DIM_W:0] my;
    logic signed [bfp_pkg::DIM_W:0] dmin;

    always_comb
    begin
        w_sat = (image_width > bfp_pkg::MAX_DIM_C) ? bfp_pkg::MAX_DIM_C : image_width;
        h_sat = (image_height > bfp_pkg::MAX_DIM_C) ? bfp_pkg::MAX_DIM_C : image_height;
        dx0   = $signed({2'b00, col});
        dy0   = $signed({2'b00, row});
        dx1   = $signed({1'b0, w_sat}) - 14'sd1 - dx0;
        dy1   = $signed({1'b0, h_sat}) - 14'sd1 - dy0;
        mx    = (dx1 < dx0) ? dx1 : dx0;
        my    = (dy1 < dy0) ? dy1 : dy0;
        dmin  = (my < mx) ? my : mx;
        data_next.chan = in_pix;
        if (dmin < 0)
        begin
            data_next.edge_dist = '0;
        end
        else
        begin
            data_next.edge_dist = dmin[bfp_pkg::CORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/bfp_class.sv
// ----------------------------------------------------------------------------
// Border fade classification stage
// Chooses fade, white or pass and forms the fade factor and channel gaps.
// ----------------------------------------------------------------------------
module bfp_class (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       in_valid,
    input  bfp_pkg::edge_t             in_data,
    input  logic [bfp_pkg::STR_W-1:0]  strength,
    output logic                       out_valid,
    output bfp_pkg::class_t            out_data
);

    logic                   vld_reg;
    bfp_pkg::class_t        data_reg;
    bfp_pkg::class_t        data_next;
    bfp_pkg::chan_t         m01;
    bfp_pkg::chan_t         mx;
    logic [bfp_pkg::STR_W-1:0] dist_ext;

    always_comb
    begin
        dist_ext = bfp_pkg::STR_W'(in_data.edge_dist);
        m01 = (in_data.chan[1] > in_data.chan[0]) ? in_data.chan[1] : in_data.chan[0];
        mx  = (in_data.chan[2] > m01) ? in_data.chan[2] : m01;
        if (dist_ext < strength)
        begin
            data_next.mode = bfp_pkg::MODE_FADE;
        end
        else if (dist_ext == strength)
        begin
            data_next.mode = bfp_pkg::MODE_WHITE;
        end
        else
        begin
            data_next.mode = bfp_pkg::MODE_PASS;
        end
        data_next.fact = strength - dist_ext;
        data_next.chan = in_data.chan;
        for (int i = 0; i < bfp_pkg::NUM_CH; i++)
        begin
            data_next.diff[i] = mx - in_data.chan[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/bfp_mul.sv
// ----------------------------------------------------------------------------
// Border fade multiply stage
// Multiplies the fade factor by each channel gap to form the dividends.
// ----------------------------------------------------------------------------
module bfp_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             in_valid,
    input  bfp_pkg::class_t  in_data,
    output logic             out_valid,
    output bfp_pkg::div_t    out_data
);

    logic           vld_reg;
    bfp_pkg::div_t  data_reg;
    bfp_pkg::div_t  data_next;

    always_comb
    begin
        data_next.mode = in_data.mode;
        data_next.chan = in_data.chan;
        for (int i = 0; i < bfp_pkg::NUM_CH; i++)
        begin
            data_next.acc[i] = bfp_pkg::NUM_W'(in_data.fact) *
                               bfp_pkg::NUM_W'(in_data.diff[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/bfp_div_step.sv
// ----------------------------------------------------------------------------
// Border fade divider stage
// Two restoring division steps per channel against the fade strength.
// ----------------------------------------------------------------------------
module bfp_div_step (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       in_valid,
    input  bfp_pkg::div_t              in_data,
    input  logic [bfp_pkg::STR_W-1:0]  strength,
    output logic                       out_valid,
    output bfp_pkg::div_t              out_data
);

    logic                      vld_reg;
    bfp_pkg::div_t             data_reg;
    bfp_pkg::div_t             data_next;
    logic [bfp_pkg::NUM_W-1:0] a;
    logic [bfp_pkg::STR_W:0]   t;
    logic [bfp_pkg::STR_W:0]   r;

    always_comb
    begin
        data_next.mode = in_data.mode;
        data_next.chan = in_data.chan;
        a = '0;
        t = '0;
        r = '0;
        for (int i = 0; i < bfp_pkg::NUM_CH; i++)
        begin
            a = in_data.acc[i];
            for (int k = 0; k < bfp_pkg::DIV_STEPS; k++)
            begin
                t = {a[bfp_pkg::NUM_W-1:bfp_pkg::CH_W], a[bfp_pkg::CH_W-1]};
                if (t >= {1'b0, strength})
                begin
                    r = t - {1'b0, strength};
                    a = {r[bfp_pkg::STR_W-1:0], a[bfp_pkg::CH_W-2:0], 1'b1};
                end
                else
                begin
                    a = {t[bfp_pkg::STR_W-1:0], a[bfp_pkg::CH_W-2:0], 1'b0};
                end
            end
            data_next.acc[i] = a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/border_fade_pixel_core.sv
// ----------------------------------------------------------------------------
// Border fade pixel core
// The core takes one pixel per cycle while the output is not stalled.
// The eight stages are distance, classify, multiply, four divider stages and output.
// Reset clears all valid bits and loads width 640, height 480 and strength 1.
// ----------------------------------------------------------------------------
module border_fade_pixel_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [bfp_pkg::CORD_W-1:0]  col,
    input  logic [bfp_pkg::CORD_W-1:0]  row,
    input  logic [bfp_pkg::CH_W-1:0]    chan0_in,
    input  logic [bfp_pkg::CH_W-1:0]    chan1_in,
    input  logic [bfp_pkg::CH_W-1:0]    chan2_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bfp_pkg::CH_W-1:0]    chan0_out,
    output logic [bfp_pkg::CH_W-1:0]    chan1_out,
    output logic [bfp_pkg::CH_W-1:0]    chan2_out
);

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_STRENGTH = 2'd2;

    localparam int S_EDGE  = 0;
    localparam int S_CLASS = 1;
    localparam int S_MUL   = 2;
    localparam int S_DIV0  = 3;
    localparam int S_OUT   = S_DIV0 + bfp_pkg::NUM_DIV;
    localparam int NUM_STG = S_OUT + 1;

    logic [bfp_pkg::DIM_W-1:0]  width_reg;
    logic [bfp_pkg::DIM_W-1:0]  height_reg;
    logic [bfp_pkg::STR_W-1:0]  strength_reg;
    logic                       cfg_wr;

    logic [NUM_STG-1:0]         vld;
    logic [NUM_STG-1:0]         en;

    bfp_pkg::pix_t              in_pix;
    logic                       edge_v;
    bfp_pkg::edge_t             edge_d;
    logic                       class_v;
    bfp_pkg::class_t            class_d;
    logic                       div_v [bfp_pkg::NUM_DIV+1];
    bfp_pkg::div_t              div_d [bfp_pkg::NUM_DIV+1];

    logic                       out_valid_reg;
    bfp_pkg::pix_t              res_reg;
    bfp_pkg::pix_t              res_next;
    bfp_pkg::div_t              fin;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 13'd640;
            height_reg   <= 13'd480;
            strength_reg <= 12'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:    width_reg    <= pwdata[bfp_pkg::DIM_W-1:0];
                REG_HEIGHT:   height_reg   <= pwdata[bfp_pkg::DIM_W-1:0];
                REG_STRENGTH: strength_reg <= pwdata[bfp_pkg::STR_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:    prdata = 32'(width_reg);
            REG_HEIGHT:   prdata = 32'(height_reg);
            REG_STRENGTH: prdata = 32'(strength_reg);
            default:      prdata = '0;
        endcase
    end

    // Each stage loads when it is empty or its successor moves on.
    always_comb
    begin
        en[NUM_STG-1] = !vld[NUM_STG-1] || !out_stall;
        for (int k = NUM_STG - 2; k >= 0; k--)
        begin
            en[k] = !vld[k] || en[k+1];
        end
    end

    assign in_stall = !en[S_EDGE];
    assign in_pix   = {chan2_in, chan1_in, chan0_in};

    bfp_edge u_edge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (en[S_EDGE]),
        .in_valid     (in_valid),
        .col          (col),
        .row          (row),
        .in_pix       (in_pix),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_valid    (edge_v),
        .out_data     (edge_d)
    );

    bfp_class u_class (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (en[S_CLASS]),
        .in_valid  (edge_v),
        .in_data   (edge_d),
        .strength  (strength_reg),
        .out_valid (class_v),
        .out_data  (class_d)
    );

    bfp_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (en[S_MUL]),
        .in_valid  (class_v),
        .in_data   (class_d),
        .out_valid (div_v[0]),
        .out_data  (div_d[0])
    );

    assign vld[S_EDGE]  = edge_v;
    assign vld[S_CLASS] = class_v;
    assign vld[S_MUL]   = div_v[0];

    for (genvar g = 0; g < bfp_pkg::NUM_DIV; g++)
    begin : g_div
        bfp_div_step u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (en[S_DIV0+g]),
            .in_valid  (div_v[g]),
            .in_data   (div_d[g]),
            .strength  (strength_reg),
            .out_valid (div_v[g+1]),
            .out_data  (div_d[g+1])
        );
        assign vld[S_DIV0+g] = div_v[g+1];
    end

    // Output stage: add the quotient, or force white, or pass through.
    assign fin = div_d[bfp_pkg::NUM_DIV];

    always_comb
    begin
        for (int i = 0; i < bfp_pkg::NUM_CH; i++)
        begin
            case (fin.mode)
                bfp_pkg::MODE_FADE:  res_next[i] = fin.chan[i] + fin.acc[i][bfp_pkg::CH_W-1:0];
                bfp_pkg::MODE_WHITE: res_next[i] = bfp_pkg::CH_MAX;
                default:             res_next[i] = fin.chan[i];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en[S_OUT])
        begin
            out_valid_reg <= div_v[bfp_pkg::NUM_DIV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            res_reg <= res_next;
        end
    end

    assign vld[S_OUT] = out_valid_reg;
    assign out_valid  = out_valid_reg;
    assign chan0_out  = res_reg[0];
    assign chan1_out  = res_reg[1];
    assign chan2_out  = res_reg[2];

`ifndef NO_ASSERTIONS
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (div_v[0] && div_d[0].mode == bfp_pkg::MODE_FADE) |->
        (div_d[0].acc[0][bfp_pkg::NUM_W-1:bfp_pkg::CH_W] < strength_reg &&
         div_d[0].acc[1][bfp_pkg::NUM_W-1:bfp_pkg::CH_W] < strength_reg &&
         div_d[0].acc[2][bfp_pkg::NUM_W-1:bfp_pkg::CH_W] < strength_reg))
        else $error("dividend too large for an eight-bit quotient");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (div_v[bfp_pkg::NUM_DIV] && fin.mode == bfp_pkg::MODE_FADE) |->
        (fin.acc[0][bfp_pkg::NUM_W-1:bfp_pkg::CH_W] < strength_reg &&
         fin.acc[1][bfp_pkg::NUM_W-1:bfp_pkg::CH_W] < strength_reg &&
         fin.acc[2][bfp_pkg::NUM_W-1:bfp_pkg::CH_W] < strength_reg))
        else $error("divider remainder not below the strength");

    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while the output stage is empty");
`endif

endmodule
